// File: sv/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and constants of the multichannel block ring FIFO.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int RING_SLOTS   = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_BLOCK    = 64;

    localparam int PTR_W  = $clog2(RING_SLOTS);
    localparam int CNT_W  = PTR_W + 1;
    localparam int CH_W   = 3;
    localparam int LEN_W  = 7;
    localparam int WORD_W = 32;
    localparam int CAP_W  = 10;
    localparam int CFG_W  = 10;

    localparam logic [2:0] MODE_PUSH        = 3'd0;
    localparam logic [2:0] MODE_PULL_STRICT = 3'd1;
    localparam logic [2:0] MODE_PULL_PART   = 3'd2;
    localparam logic [2:0] MODE_PULL_NEWEST = 3'd3;
    localparam logic [2:0] MODE_SET_READ    = 3'd4;
    localparam logic [2:0] MODE_SET_WRITE   = 3'd5;
    localparam logic [2:0] MODE_CLEAR       = 3'd6;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_CHANNELS = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [LEN_W-1:0]  blk_len;
        logic              advance;
        logic              last_frame;
        logic [WORD_W-1:0] sample_0;
        logic [WORD_W-1:0] sample_1;
        logic [WORD_W-1:0] sample_2;
        logic [WORD_W-1:0] sample_3;
        logic [CAP_W-1:0]  pointer_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              rejected;
        logic [LEN_W-1:0]  frame_count;
        logic [WORD_W-1:0] out_0;
        logic [WORD_W-1:0] out_1;
        logic [WORD_W-1:0] out_2;
        logic [WORD_W-1:0] out_3;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic             we;
        logic             clr;
        logic [PTR_W-1:0] wr_addr;
        logic [PTR_W-1:0] rd_addr;
    } ram_ctl_t;

    typedef struct packed {
        logic             load;
        logic [1:0]       kind;
        logic             rejected;
        logic [LEN_W-1:0] frame_count;
        logic             last;
        logic             use_frame;
    } res_t;

endpackage

// File: sv/rbf_ram.sv
// ----------------------------------------------------------------------------
// rbf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/rbf_lane.sv
// ----------------------------------------------------------------------------
// rbf_lane
// One channel lane: the channel's word store, write gating and read masking.
// ----------------------------------------------------------------------------
module rbf_lane (
    input  logic                    clk,
    input  rbf_pkg::ram_ctl_t       ctl,
    input  logic                    lane_en,
    input  logic [rbf_pkg::WORD_W-1:0] wr_word,
    output logic [rbf_pkg::WORD_W-1:0] rd_word
);
    import rbf_pkg::*;

    logic              we;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    // the clearing sweep hits every lane; a push only the channels in use
    assign we      = ctl.we && (ctl.clr || lane_en);
    assign wr_data = ctl.clr ? '0 : wr_word;
    assign rd_word = lane_en ? rd_data : '0;

    rbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_SLOTS)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (ctl.wr_addr),
        .wr_data (wr_data),
        .rd_addr (ctl.rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: sv/rbf_ctrl.sv
// ----------------------------------------------------------------------------
// rbf_ctrl
// Pointer bookkeeping, request decode, pull sequencer and clearing sweep.
// ----------------------------------------------------------------------------
module rbf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  rbf_pkg::in_item_t           item,
    input  logic                        out_free,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [rbf_pkg::CFG_W-1:0]   cfg_wdata,
    output rbf_pkg::ram_ctl_t           ram_ctl,
    output rbf_pkg::res_t               res,
    output logic [rbf_pkg::MAX_CHANNELS-1:0] lane_en
);
    import rbf_pkg::*;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [LEN_W-1:0]  offset_reg, offset_next;
    logic              rejecting_reg, rejecting_next;
    logic              in_block_reg, in_block_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CH_W-1:0]   chans_reg, chans_next;
    logic [PTR_W-1:0]  sweep_reg, sweep_next;
    logic [PTR_W-1:0]  slot_reg, slot_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              accept;
    logic [CNT_W-1:0]  slots;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  free_now;
    logic [CH_W-1:0]   nc;

    // push terms
    logic              first;
    logic              rej;
    logic [LEN_W-1:0]  off;
    logic              wr_ok;
    logic [LEN_W-1:0]  off_new;
    logic [CNT_W-1:0]  push_slot;

    // pull terms
    logic [LEN_W-1:0]  n0;
    logic              short_data;
    logic              strict;
    logic [LEN_W-1:0]  n;
    logic              pull_empty;
    logic [CNT_W-1:0]  start;
    logic              last_frame_out;

    // set and config terms
    logic [CNT_W-1:0]  pv_clamped;
    logic [CNT_W-1:0]  cfg_slots;

    function automatic logic [CNT_W-1:0] wrap(input logic [CNT_W-1:0] sum,
                                              input logic [CNT_W-1:0] s);
        wrap = (sum >= s) ? sum - s : sum;
    endfunction

    function automatic logic [CNT_W-1:0] slots_of(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] c;
        c = {{(CNT_W-CAP_W){1'b0}}, cap};
        if (c == '0)
        begin
            c = CNT_W'(1);
        end
        if (c > CNT_W'(RING_SLOTS - 1))
        begin
            c = CNT_W'(RING_SLOTS - 1);
        end
        slots_of = c + CNT_W'(1);
    endfunction

    assign item_ready = (state_reg == ST_IDLE) && out_free;
    assign accept     = item_valid && item_ready;

    assign slots    = slots_of(cap_reg);
    assign avail    = (wp_reg >= rp_reg) ? CNT_W'(wp_reg) - CNT_W'(rp_reg)
                                         : CNT_W'(wp_reg) + slots - CNT_W'(rp_reg);
    assign free_now = slots - CNT_W'(1) - avail;

    always_comb
    begin
        nc = chans_reg;
        if (nc == '0)
        begin
            nc = CH_W'(1);
        end
        if (nc > CH_W'(MAX_CHANNELS))
        begin
            nc = CH_W'(MAX_CHANNELS);
        end
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            lane_en[c] = (CH_W'(c) < nc);
        end
    end

    // push decode
    assign first     = !in_block_reg;
    assign rej       = first ? (free_now < CNT_W'(item.blk_len)) : rejecting_reg;
    assign off       = first ? '0 : offset_reg;
    assign wr_ok     = !rej && (CNT_W'(off) < free_now) && (off < LEN_W'(MAX_BLOCK));
    assign off_new   = off + LEN_W'(wr_ok);
    assign push_slot = wrap(CNT_W'(wp_reg) + CNT_W'(off), slots);

    // pull decode
    assign n0         = (item.blk_len > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                           : item.blk_len;
    assign short_data = avail < CNT_W'(n0);
    assign strict     = (item.mode == MODE_PULL_STRICT);
    assign n          = (!strict && short_data) ? avail[LEN_W-1:0] : n0;
    assign pull_empty = (strict && short_data) || (n == '0);
    assign start      = (item.mode == MODE_PULL_NEWEST)
                        ? wrap(CNT_W'(wp_reg) + slots - CNT_W'(n), slots)
                        : CNT_W'(rp_reg);
    assign last_frame_out = (idx_reg + LEN_W'(1) == n_reg);

    assign pv_clamped = (CNT_W'(item.pointer_value) >= slots) ? slots - CNT_W'(1)
                                                              : CNT_W'(item.pointer_value);
    assign cfg_slots  = slots_of(cfg_wdata[CAP_W-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_reg == PTR_W'(RING_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode) inside
                        MODE_PULL_STRICT, MODE_PULL_PART, MODE_PULL_NEWEST:
                        begin
                            if (!pull_empty)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    state_next = last_frame_out ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        offset_next    = offset_reg;
        rejecting_next = rejecting_reg;
        in_block_next  = in_block_reg;
        cap_next       = cap_reg;
        chans_next     = chans_reg;
        sweep_next     = sweep_reg;
        slot_next      = slot_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;

        ram_ctl.we      = 1'b0;
        ram_ctl.clr     = 1'b0;
        ram_ctl.wr_addr = push_slot[PTR_W-1:0];
        ram_ctl.rd_addr = slot_reg;

        res.load        = 1'b0;
        res.kind        = KIND_PUSH;
        res.rejected    = 1'b0;
        res.frame_count = '0;
        res.last        = 1'b1;
        res.use_frame   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.we      = 1'b1;
                ram_ctl.clr     = 1'b1;
                ram_ctl.wr_addr = sweep_reg;
                sweep_next      = sweep_reg + PTR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode) inside
                        MODE_PUSH:
                        begin
                            ram_ctl.we   = wr_ok;
                            res.load     = 1'b1;
                            res.kind     = KIND_PUSH;
                            res.rejected = rej;
                            if (item.last_frame)
                            begin
                                if (!rej)
                                begin
                                    wp_next = PTR_W'(wrap(CNT_W'(wp_reg) + CNT_W'(off_new),
                                                          slots));
                                end
                                offset_next    = '0;
                                rejecting_next = 1'b0;
                                in_block_next  = 1'b0;
                            end
                            else
                            begin
                                offset_next    = off_new;
                                rejecting_next = rej;
                                in_block_next  = 1'b1;
                            end
                        end
                        MODE_PULL_STRICT, MODE_PULL_PART, MODE_PULL_NEWEST:
                        begin
                            if (pull_empty)
                            begin
                                res.load     = 1'b1;
                                res.kind     = KIND_EMPTY;
                                res.rejected = strict && short_data;
                            end
                            else
                            begin
                                slot_next = start[PTR_W-1:0];
                                n_next    = n;
                                idx_next  = '0;
                                if (item.advance)
                                begin
                                    rp_next = PTR_W'(wrap(CNT_W'(rp_reg) + CNT_W'(n),
                                                          slots));
                                end
                            end
                        end
                        MODE_SET_READ:
                        begin
                            rp_next = pv_clamped[PTR_W-1:0];
                        end
                        MODE_SET_WRITE:
                        begin
                            wp_next        = pv_clamped[PTR_W-1:0];
                            offset_next    = '0;
                            rejecting_next = 1'b0;
                            in_block_next  = 1'b0;
                        end
                        MODE_CLEAR:
                        begin
                            rp_next        = '0;
                            wp_next        = '0;
                            offset_next    = '0;
                            rejecting_next = 1'b0;
                            in_block_next  = 1'b0;
                            sweep_next     = '0;
                        end
                        default:
                        begin
                            rp_next = rp_reg;
                        end
                    endcase
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    res.load        = 1'b1;
                    res.kind        = KIND_FRAME;
                    res.frame_count = n_reg;
                    res.last        = last_frame_out;
                    res.use_frame   = 1'b1;
                    slot_next = (CNT_W'(slot_reg) + CNT_W'(1) == slots)
                                ? '0 : slot_reg + PTR_W'(1);
                    idx_next  = idx_reg + LEN_W'(1);
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase

        // register writes; a capacity write pulls the pointers inside the new ring size
        if (cfg_we)
        begin
            if (cfg_index == CFG_CAPACITY)
            begin
                cap_next = cfg_wdata[CAP_W-1:0];
                if (CNT_W'(rp_reg) >= cfg_slots)
                begin
                    rp_next = PTR_W'(cfg_slots - CNT_W'(1));
                end
                if (CNT_W'(wp_reg) >= cfg_slots)
                begin
                    wp_next = PTR_W'(cfg_slots - CNT_W'(1));
                end
            end
            else
            begin
                chans_next = cfg_wdata[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rp_reg        <= '0;
            wp_reg        <= '0;
            offset_reg    <= '0;
            rejecting_reg <= 1'b0;
            in_block_reg  <= 1'b0;
            cap_reg       <= CAP_W'(1023);
            chans_reg     <= CH_W'(2);
            sweep_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            offset_reg    <= offset_next;
            rejecting_reg <= rejecting_next;
            in_block_reg  <= in_block_next;
            cap_reg       <= cap_next;
            chans_reg     <= chans_next;
            sweep_reg     <= sweep_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        n_reg    <= n_next;
    end

endmodule

// File: sv/multichannel_block_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// multichannel_block_ring_fifo_unit
// Ring FIFO of audio frames, one word store lane per channel.
// ----------------------------------------------------------------------------
// Requests come in on item_valid/item_ready with an in_item_t payload; results
// leave on result_valid/result_ready as out_item_t. Registers are written
// through cfg_we/cfg_index/cfg_wdata (0 capacity, 1 channels_used).
// A push frame's status result appears in the cycle after the request. A
// pull runs from the read (or write) pointer and takes no new request until
// its last frame is out. Each frame passes the single slot address register,
// the registered read of the lane memories (ST_READ) and the output register
// (ST_DATA). Empty or rejected pulls answer in the cycle after the request;
// set commands give no result. After reset, and after a clear request, the
// block sweeps zeros through all 1024 slots of every lane, one slot per
// cycle, and takes no request until the sweep ends; register writes are
// taken throughout. Results sit in an output register; while the receiver
// stalls, a pull in progress pauses on its current frame and no new request
// is taken until the register frees.
// ----------------------------------------------------------------------------
module multichannel_block_ring_fifo_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  rbf_pkg::in_item_t          item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output rbf_pkg::out_item_t         result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [rbf_pkg::CFG_W-1:0]  cfg_wdata
);
    import rbf_pkg::*;

    ram_ctl_t              ram_ctl;
    res_t                  res;
    logic [MAX_CHANNELS-1:0] lane_en;
    logic                  out_free;
    logic [WORD_W-1:0]     wr_word [MAX_CHANNELS];
    logic [WORD_W-1:0]     rd_word [MAX_CHANNELS];

    logic                  valid_reg;
    out_item_t             result_reg;

    assign out_free     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign wr_word[0] = item.sample_0;
    assign wr_word[1] = item.sample_1;
    assign wr_word[2] = item.sample_2;
    assign wr_word[3] = item.sample_3;

    rbf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_free   (out_free),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ram_ctl    (ram_ctl),
        .res        (res),
        .lane_en    (lane_en)
    );

    for (genvar c = 0; c < MAX_CHANNELS; c++)
    begin : g_lane
        rbf_lane u_lane (
            .clk     (clk),
            .ctl     (ram_ctl),
            .lane_en (lane_en[c]),
            .wr_word (wr_word[c]),
            .rd_word (rd_word[c])
        );
    end

    // merge the lane words and the sequencer status into one result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            result_reg.kind        <= res.kind;
            result_reg.rejected    <= res.rejected;
            result_reg.frame_count <= res.frame_count;
            result_reg.last_of_run <= res.last;
            result_reg.out_0       <= res.use_frame ? rd_word[0] : '0;
            result_reg.out_1       <= res.use_frame ? rd_word[1] : '0;
            result_reg.out_2       <= res.use_frame ? rd_word[2] : '0;
            result_reg.out_3       <= res.use_frame ? rd_word[3] : '0;
        end
    end

endmodule
